// File: rtl/rgb565_to_gray2_page_packer_defines.svh
// ----------------------------------------------------------------------------
// RGB565 to 2-bit gray page packer: assertion macros
// Shared assertion helpers for the packer's own checks.
// ----------------------------------------------------------------------------
`ifndef RGB565_TO_GRAY2_PAGE_PACKER_DEFINES_SVH
`define RGB565_TO_GRAY2_PAGE_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define RGBG2_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packer check failed");
`define RGBG2_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packer check failed");
`else
`define RGBG2_ASSERT_IMP(label, clk, rst, ante, cons)
`define RGBG2_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/rgbg2_pkg.sv
// ----------------------------------------------------------------------------
// RGB565 to 2-bit gray page packer: package
// Geometry, weights, thresholds and shared types.
// ----------------------------------------------------------------------------
package rgbg2_pkg;

  localparam int COLUMNS    = 128;
  localparam int PAGE_COUNT = 16;
  localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = 2;
  localparam int MID_CW    = 3;
  localparam int OUT_DEPTH = 2;
  localparam int OUT_AW    = 1;
  localparam int OUT_CW    = 2;

  localparam logic [15:0] MASK_C0 = 16'h001f;
  localparam logic [15:0] MASK_C1 = 16'h07e0;
  localparam logic [15:0] MASK_C2 = 16'hf800;

  localparam logic [15:0] WEIGHT_C0 = 16'd19595;
  localparam logic [15:0] WEIGHT_C1 = 16'd38469;
  localparam logic [15:0] WEIGHT_C2 = 16'd7472;

  localparam logic [5:0] THRESH_LOW  = 6'd12;
  localparam logic [5:0] THRESH_MID  = 6'd25;
  localparam logic [5:0] THRESH_HIGH = 6'd37;

  typedef enum logic [1:0] {
    BAND_BLACK = 2'd0,
    BAND_DARK  = 2'd1,
    BAND_LIGHT = 2'd2,
    BAND_WHITE = 2'd3
  } band_t;

  typedef struct packed {
    logic set_first;
    logic set_second;
  } plane_bits_t;

  typedef struct packed {
    logic [MID_CW-1:0] count;
    logic              empty;
  } queue_status_t;

  typedef struct packed {
    logic [3:0] page_index;
    logic [6:0] column_index;
    logic [7:0] plane_first;
    logic [7:0] plane_second;
    logic       frame_end;
  } result_t;

  function automatic band_t band_of(input logic [5:0] gray);
    band_t band;
    if (gray < THRESH_LOW) begin
      band = BAND_BLACK;
    end else if (gray < THRESH_MID) begin
      band = BAND_DARK;
    end else if (gray < THRESH_HIGH) begin
      band = BAND_LIGHT;
    end else begin
      band = BAND_WHITE;
    end
    return band;
  endfunction

  function automatic plane_bits_t classify(input logic [5:0] gray, input logic reverse);
    plane_bits_t bits;
    band_t band;
    band = band_of(gray);
    bits = '0;
    case (band)
      BAND_BLACK: begin
        bits.set_first  = !reverse;
        bits.set_second = !reverse;
      end
      BAND_DARK: begin
        bits.set_first  = reverse;
        bits.set_second = !reverse;
      end
      BAND_LIGHT: begin
        bits.set_first  = !reverse;
        bits.set_second = reverse;
      end
      BAND_WHITE: begin
        bits.set_first  = reverse;
        bits.set_second = reverse;
      end
      default: begin
        bits = '0;
      end
    endcase
    return bits;
  endfunction

endpackage

// File: rtl/rgbg2_front.sv
// ----------------------------------------------------------------------------
// RGB565 to 2-bit gray page packer: front end
// Weighs the color channels, then sorts the gray value into a plane bit pair.
// ----------------------------------------------------------------------------
module rgbg2_front import rgbg2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] pixel,
  input  logic        reverse,
  output logic        wr_valid,
  output plane_bits_t wr_bits
);

  logic [4:0]  c0;
  logic [5:0]  c1;
  logic [4:0]  c2;
  logic        s1_valid;
  logic        s1_reverse;
  logic [19:0] prod0;
  logic [21:0] prod1;
  logic [17:0] prod2;
  logic [22:0] sum;
  logic [5:0]  gray;

  assign c0 = 5'(pixel & MASK_C0);
  assign c1 = 6'((pixel & MASK_C1) >> 5);
  assign c2 = 5'((pixel & MASK_C2) >> 11);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_reverse <= reverse;
      prod0      <= {15'd0, c0} * {4'd0, WEIGHT_C0};
      prod1      <= {16'd0, c1} * {6'd0, WEIGHT_C1};
      prod2      <= {13'd0, c2} * {2'd0, WEIGHT_C2};
    end
  end

  assign sum      = {3'd0, prod0} + {1'd0, prod1} + {5'd0, prod2};
  assign gray     = sum[21:16];
  assign wr_valid = s1_valid;
  assign wr_bits  = classify(gray, s1_reverse);

endmodule

// File: rtl/rgbg2_queue.sv
// ----------------------------------------------------------------------------
// RGB565 to 2-bit gray page packer: classified item queue
// Short queue that decouples the front end from the packing back end.
// ----------------------------------------------------------------------------
module rgbg2_queue import rgbg2_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  plane_bits_t   wr_data,
  input  logic          rd,
  output plane_bits_t   rd_data,
  output queue_status_t status
);

  plane_bits_t       mem [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr;
  logic [MID_AW-1:0] rd_ptr;
  logic [MID_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data      = mem[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

endmodule

// File: rtl/rgbg2_back.sv
// ----------------------------------------------------------------------------
// RGB565 to 2-bit gray page packer: back end
// Builds the two plane bytes per column, steps column and page, and queues
// finished columns for the result side.
// ----------------------------------------------------------------------------
module rgbg2_back import rgbg2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  plane_bits_t q_data,
  output logic        q_rd,
  input  logic        pop,
  output logic        empty,
  output result_t     result
);

  logic [7:0]        first_accum;
  logic [7:0]        second_accum;
  logic [2:0]        row_in_page;
  logic [COL_W-1:0]  column_count;
  logic [PAGE_W-1:0] page_count;
  logic [7:0]        row_bit;
  logic [7:0]        first_next;
  logic [7:0]        second_next;
  logic              last_row;
  logic              last_column;
  logic              last_page;
  logic              emit;
  logic              do_pop;
  result_t           fresh;

  result_t           out_mem [OUT_DEPTH];
  logic [OUT_AW-1:0] out_wr;
  logic [OUT_AW-1:0] out_rd;
  logic [OUT_CW-1:0] out_count;

  assign last_row    = (row_in_page == 3'd7);
  assign last_column = (column_count == COL_W'(COLUMNS - 1));
  assign last_page   = (page_count == PAGE_W'(PAGE_COUNT - 1));
  assign q_rd        = !q_empty && (!last_row || (out_count < OUT_CW'(OUT_DEPTH)));
  assign emit        = q_rd && last_row;
  assign do_pop      = pop && !empty;

  assign row_bit     = 8'd1 << row_in_page;
  assign first_next  = first_accum | (q_data.set_first ? row_bit : 8'd0);
  assign second_next = second_accum | (q_data.set_second ? row_bit : 8'd0);

  assign fresh.page_index   = 4'(page_count);
  assign fresh.column_index = 7'(column_count);
  assign fresh.plane_first  = first_next;
  assign fresh.plane_second = second_next;
  assign fresh.frame_end    = last_column && last_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_accum  <= '0;
      second_accum <= '0;
      row_in_page  <= '0;
      column_count <= '0;
      page_count   <= '0;
    end else if (q_rd) begin
      if (last_row) begin
        first_accum  <= '0;
        second_accum <= '0;
        row_in_page  <= '0;
        if (last_column) begin
          column_count <= '0;
          page_count   <= last_page ? '0 : page_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end else begin
        first_accum  <= first_next;
        second_accum <= second_next;
        row_in_page  <= row_in_page + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (emit) begin
        out_wr <= out_wr + 1'b1;
      end
      if (do_pop) begin
        out_rd <= out_rd + 1'b1;
      end
      case ({emit, do_pop})
        2'b10:   out_count <= out_count + 1'b1;
        2'b01:   out_count <= out_count - 1'b1;
        default: out_count <= out_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mem[out_wr] <= fresh;
    end
  end

  assign empty  = (out_count == '0);
  assign result = out_mem[out_rd];

endmodule

// File: rtl/rgb565_to_gray2_page_packer.sv
// A column's eighth pixel is registered, queued, then packed into the result queue.
// Throughput: one pixel per cycle while full stays low, one result for every eight pixels.
// The back end sets the rate: one queued pixel per cycle, held while the result queue is full.
// Reset (rst, synchronous, active high) clears counters, plane bytes, queues
// and the reverse_levels register.
// ----------------------------------------------------------------------------
// RGB565 to 2-bit gray page packer
// Converts page-ordered RGB565 pixels to two plane bytes per column.
// ----------------------------------------------------------------------------
`include "rgb565_to_gray2_page_packer_defines.svh"

module rgb565_to_gray2_page_packer import rgbg2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] pixel_rgb565,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  page_index,
  output logic [6:0]  column_index,
  output logic [7:0]  plane_first,
  output logic [7:0]  plane_second,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic          reverse_levels;
  logic          accept;
  logic          mid_wr;
  plane_bits_t   mid_wr_bits;
  logic          mid_rd;
  plane_bits_t   mid_rd_bits;
  queue_status_t mid_status;
  logic [MID_CW:0] credit_used;
  result_t       result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_levels <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      reverse_levels <= cfg_data;
    end
  end

  // Items still in the front stage count against the queue space.
  assign credit_used = {1'b0, mid_status.count} + {{MID_CW{1'b0}}, mid_wr};
  assign full        = (credit_used >= (MID_CW + 1)'(MID_DEPTH));
  assign accept      = push && !full;

  rgbg2_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pixel    (pixel_rgb565),
    .reverse  (reverse_levels),
    .wr_valid (mid_wr),
    .wr_bits  (mid_wr_bits)
  );

  rgbg2_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (mid_wr),
    .wr_data (mid_wr_bits),
    .rd      (mid_rd),
    .rd_data (mid_rd_bits),
    .status  (mid_status)
  );

  rgbg2_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (mid_status.empty),
    .q_data  (mid_rd_bits),
    .q_rd    (mid_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  assign page_index   = result.page_index;
  assign column_index = result.column_index;
  assign plane_first  = result.plane_first;
  assign plane_second = result.plane_second;
  assign frame_end    = result.frame_end;

  `RGBG2_ASSERT_IMP(a_mid_no_overflow, clk, rst, mid_wr, mid_status.count != MID_CW'(MID_DEPTH))
  `RGBG2_ASSERT_IMP(a_mid_no_underflow, clk, rst, mid_rd, !mid_status.empty)
  `RGBG2_ASSERT_NEXT(a_accept_reaches_queue, clk, rst, accept, mid_wr)
  `RGBG2_ASSERT_IMP(a_frame_end_page, clk, rst, !empty && frame_end, page_index == 4'(PAGE_COUNT - 1))

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the RGB565 to 2-bit gray page packer
// Streams pixels through the push/full side and pops column results through
// the empty/pop side. A scoreboard keeps its own copy of the row, column and
// page counters and of the plane accumulators, and computes the expected
// plane bytes for every column. It then compares each popped result field by
// field. The run covers band edges, mode changes in the middle of a column,
// and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top import rgbg2_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int CYCLE_LIMIT    = 1000000;

  class plane_byte_scoreboard;
    result_t     expected_columns[$];
    bit          reverse;
    logic [7:0]  first_acc = '0;
    logic [7:0]  second_acc = '0;
    logic [2:0]  row = '0;
    int          col_count;
    int          page_count;
    int          mismatches;
    int          columns_checked;
    int          frame_ends;
    int          band_hits[4];

    function void set_reverse(input bit value);
      reverse = value;
    endfunction

    function int pending();
      return expected_columns.size();
    endfunction

    function band_t pixel_band(input logic [15:0] px);
      int unsigned gray;
      gray = (int'(px[4:0]) * int'(WEIGHT_C0) + int'(px[10:5]) * int'(WEIGHT_C1) +
              int'(px[15:11]) * int'(WEIGHT_C2)) >> 16;
      if (gray < THRESH_LOW) begin
        return BAND_BLACK;
      end else if (gray < THRESH_MID) begin
        return BAND_DARK;
      end else if (gray < THRESH_HIGH) begin
        return BAND_LIGHT;
      end
      return BAND_WHITE;
    endfunction

    function void note_pixel(input logic [15:0] px);
      band_t   band;
      bit      set_first;
      bit      set_second;
      result_t column;
      band = pixel_band(px);
      band_hits[band]++;
      if (!reverse) begin
        set_first  = (band == BAND_BLACK) || (band == BAND_LIGHT);
        set_second = (band == BAND_BLACK) || (band == BAND_DARK);
      end else begin
        set_first  = (band == BAND_DARK) || (band == BAND_WHITE);
        set_second = (band == BAND_LIGHT) || (band == BAND_WHITE);
      end
      if (set_first) first_acc[row] = 1'b1;
      if (set_second) second_acc[row] = 1'b1;
      if (row != 3'd7) begin
        row++;
        return;
      end
      column.page_index   = page_count[3:0];
      column.column_index = col_count[6:0];
      column.plane_first  = first_acc;
      column.plane_second = second_acc;
      column.frame_end    = (col_count >= COLUMNS - 1) && (page_count >= PAGE_COUNT - 1);
      expected_columns.push_back(column);
      first_acc  = '0;
      second_acc = '0;
      row        = '0;
      if (col_count >= COLUMNS - 1) begin
        col_count = 0;
        page_count = (page_count >= PAGE_COUNT - 1) ? 0 : page_count + 1;
      end else begin
        col_count++;
      end
    endfunction

    function void check_column(input result_t got);
      result_t want;
      bit      ok;
      columns_checked++;
      if (got.frame_end === 1'b1) frame_ends++;
      if (expected_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected column result: page %0d column %0d first %02h second %02h end %0b",
                   got.page_index, got.column_index, got.plane_first, got.plane_second,
                   got.frame_end);
        end
        return;
      end
      want = expected_columns.pop_front();
      ok = (got.page_index === want.page_index) && (got.column_index === want.column_index) &&
           (got.plane_first === want.plane_first) &&
           (got.plane_second === want.plane_second) && (got.frame_end === want.frame_end);
      if (!ok) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Column mismatch: expected page %0d column %0d first %02h second %02h end %0b",
                   want.page_index, want.column_index, want.plane_first, want.plane_second,
                   want.frame_end);
          $display("                 actual   page %0d column %0d first %02h second %02h end %0b",
                   got.page_index, got.column_index, got.plane_first, got.plane_second,
                   got.frame_end);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] pixel_rgb565 = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  page_index;
  logic [6:0]  column_index;
  logic [7:0]  plane_first;
  logic [7:0]  plane_second;
  logic        frame_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  plane_byte_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int pixels_sent = 0;
  int mode_writes = 0;
  int cycle_count = 0;

  logic [15:0] edge_pixels[8] = '{16'h0000, 16'hffff, 16'h0280, 16'h02a0,
                                  16'h0520, 16'h0560, 16'h07c0, 16'h07e1};
  logic [15:0] directed_pixels[24] = '{
    16'h0000, 16'hffff, 16'h001f, 16'h07e0, 16'hf800, 16'h0280, 16'h02a0, 16'h0520,
    16'h0560, 16'h07c0, 16'h07e1, 16'h02a0, 16'h0000, 16'hffff, 16'h0280, 16'h02a0,
    16'h0520, 16'h0560, 16'h07c0, 16'h07e1, 16'h5555, 16'haaaa, 16'h02a0, 16'hffff};

  rgb565_to_gray2_page_packer i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pixel_rgb565 (pixel_rgb565),
    .empty        (empty),
    .pop          (pop),
    .page_index   (page_index),
    .column_index (column_index),
    .plane_first  (plane_first),
    .plane_second (plane_second),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d columns outstanding.",
               cycle_count, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(negedge clk) begin
    result_t got;
    if (!rst && pop && !empty) begin
      got.page_index   = page_index;
      got.column_index = column_index;
      got.plane_first  = plane_first;
      got.plane_second = plane_second;
      got.frame_end    = frame_end;
      sb.check_column(got);
    end
  end

  task automatic send_pixel(input logic [15:0] px);
    bit taken;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel_rgb565 <= px;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic drain_columns();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reverse(input bit value);
    bit taken;
    drain_columns();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    sb.set_reverse(value);
    mode_writes++;
  endtask

  function automatic logic [15:0] random_pixel();
    logic [15:0] px;
    case ($urandom_range(9))
      0: px = edge_pixels[$urandom_range(7)];
      1: px = 16'($urandom()) & MASK_C0;
      2: px = 16'($urandom()) & MASK_C1;
      3: px = 16'($urandom()) & MASK_C2;
      4: px = $urandom_range(1) ? 16'hffff : 16'h0000;
      default: px = 16'($urandom());
    endcase
    return px;
  endfunction

  task automatic run_random(input int sender_pct, input int receiver_pct, input int count);
    send_idle = sender_pct;
    recv_idle = receiver_pct;
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reverse(1'b0);
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 24; i++) begin
      // Switching to reversed levels in the middle of a column.
      if (i == 12) write_reverse(1'b1);
      send_pixel(directed_pixels[i]);
    end

    write_reverse(1'b0);
    run_random(33, 81, 400);
    write_reverse(1'b1);
    run_random(81, 33, 400);
    write_reverse(1'b0);
    run_random(0, 0, 350);
    drain_columns();

    $display("Sent %0d pixels in %0d mode writes; checked %0d columns, %0d frame ends seen.",
             pixels_sent, mode_writes, sb.columns_checked, sb.frame_ends);
    $display("Pixels per band, dark to light: %0d %0d %0d %0d; %0d mismatches.",
             sb.band_hits[0], sb.band_hits[1], sb.band_hits[2], sb.band_hits[3],
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: rgb565_to_gray2_page_packer.f
+incdir+rtl
rtl/rgbg2_pkg.sv
rtl/rgbg2_front.sv
rtl/rgbg2_queue.sv
rtl/rgbg2_back.sv
rtl/rgb565_to_gray2_page_packer.sv
tb/tb_top.sv
